// ===== rtl/core/pcan_pkg.sv =====
// pcan_pkg: shared types and constants for the path canonicalizer.
// Used by pcan_front, pcan_queue, pcan_back and path_canonicalizer.
// No dependencies.
package pcan_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] OP_BASE   = 2'd0;
    localparam logic [1:0] OP_PATH   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_APPEND,
        CMD_ROOT,
        CMD_BACKUP,
        CMD_FINISH,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_OPEN,
        PRE_ENSURE
    } pre_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_in;
        logic [11:0] read_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] result_length;
        logic [7:0]  char_out;
    } result_t;

    typedef struct packed {
        cmd_kind_t   kind;
        pre_t        pre;
        logic [1:0]  dots;
        logic        with_char;
        logic        fin_backup;
        logic        started;
        logic [7:0]  ch;
        logic [11:0] read_index;
    } cmd_t;

endpackage

// ===== rtl/core/pcan_front.sv =====
// pcan_front: accepts input transfers, tracks component phase and path start,
// and turns each item into a back-end command. Depends on pcan_pkg.
module pcan_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  pcan_pkg::item_t item,
    input  logic            q_full,
    output logic            push,
    output pcan_pkg::cmd_t  push_cmd
);

    typedef enum logic [1:0] {
        PH_START,
        PH_DOT,
        PH_DOTDOT,
        PH_NAME
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   started_reg, started_next;
    logic   is_slash, is_dot, is_nul;
    pcan_pkg::cmd_t cmd;

    assign is_slash   = (item.char_in == pcan_pkg::CH_SLASH);
    assign is_dot     = (item.char_in == pcan_pkg::CH_DOT);
    assign is_nul     = (item.char_in == pcan_pkg::CH_NUL);
    assign item_stall = q_full;
    assign push       = item_valid && !q_full;
    assign push_cmd   = cmd;

    always_comb
    begin
        phase_next     = phase_reg;
        started_next   = started_reg;
        cmd            = '0;
        cmd.kind       = pcan_pkg::CMD_NOP;
        cmd.pre        = pcan_pkg::PRE_NONE;
        cmd.ch         = item.char_in;
        cmd.read_index = item.read_index;
        case (item.operation)
            pcan_pkg::OP_BASE:
            begin
                if (!started_reg && !is_nul)
                begin
                    cmd.kind      = pcan_pkg::CMD_APPEND;
                    cmd.with_char = 1'b1;
                end
            end
            pcan_pkg::OP_PATH:
            begin
                if (!is_nul)
                begin
                    if (!started_reg)
                    begin
                        started_next = 1'b1;
                        phase_next   = PH_START;
                        if (is_slash)
                        begin
                            cmd.kind = pcan_pkg::CMD_ROOT;
                        end
                        else
                        begin
                            cmd.kind = pcan_pkg::CMD_APPEND;
                            cmd.pre  = pcan_pkg::PRE_ENSURE;
                            if (is_dot)
                            begin
                                phase_next = PH_DOT;
                            end
                            else
                            begin
                                cmd.with_char = 1'b1;
                                phase_next    = PH_NAME;
                            end
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (is_dot)
                                begin
                                    phase_next = PH_DOT;
                                end
                                else if (!is_slash)
                                begin
                                    cmd.kind      = pcan_pkg::CMD_APPEND;
                                    cmd.pre       = pcan_pkg::PRE_OPEN;
                                    cmd.with_char = 1'b1;
                                    phase_next    = PH_NAME;
                                end
                            end
                            PH_DOT:
                            begin
                                if (is_slash)
                                begin
                                    phase_next = PH_START;
                                end
                                else if (is_dot)
                                begin
                                    phase_next = PH_DOTDOT;
                                end
                                else
                                begin
                                    cmd.kind      = pcan_pkg::CMD_APPEND;
                                    cmd.pre       = pcan_pkg::PRE_OPEN;
                                    cmd.dots      = 2'd1;
                                    cmd.with_char = 1'b1;
                                    phase_next    = PH_NAME;
                                end
                            end
                            PH_DOTDOT:
                            begin
                                if (is_slash)
                                begin
                                    cmd.kind   = pcan_pkg::CMD_BACKUP;
                                    phase_next = PH_START;
                                end
                                else
                                begin
                                    cmd.kind      = pcan_pkg::CMD_APPEND;
                                    cmd.pre       = pcan_pkg::PRE_OPEN;
                                    cmd.dots      = 2'd2;
                                    cmd.with_char = 1'b1;
                                    phase_next    = PH_NAME;
                                end
                            end
                            default:
                            begin
                                cmd.kind      = pcan_pkg::CMD_APPEND;
                                cmd.with_char = 1'b1;
                                if (is_slash)
                                begin
                                    phase_next = PH_START;
                                end
                            end
                        endcase
                    end
                end
            end
            pcan_pkg::OP_FINISH:
            begin
                if (started_reg)
                begin
                    cmd.kind       = pcan_pkg::CMD_FINISH;
                    cmd.fin_backup = (phase_reg == PH_DOTDOT);
                    phase_next     = PH_START;
                end
            end
            default:
            begin
                cmd.kind = pcan_pkg::CMD_READ;
            end
        endcase
        cmd.started = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            started_reg <= 1'b0;
        end
        else if (push)
        begin
            phase_reg   <= phase_next;
            started_reg <= started_next;
        end
    end

endmodule

// ===== rtl/core/pcan_queue.sv =====
// pcan_queue: two-entry command queue between front and back end.
// Depends on pcan_pkg.
module pcan_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcan_pkg::cmd_t push_cmd,
    input  logic           pop,
    output pcan_pkg::cmd_t pop_cmd,
    output logic           full,
    output logic           empty
);

    pcan_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue pop while empty");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

// ===== rtl/core/pcan_back.sv =====
// pcan_back: executes commands against the path buffer and holds the result register.
// Depends on pcan_pkg.
module pcan_back #(
    parameter int PATH_CAPACITY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pcan_pkg::cmd_t    q_data,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output pcan_pkg::result_t result
);

    localparam int AW = $clog2(PATH_CAPACITY);
    localparam int LW = $clog2(PATH_CAPACITY + 1);
    localparam int CW = (LW > 12) ? LW : 12;
    localparam int XW = (LW > 13) ? LW : 13;
    localparam logic [LW-1:0] CAP_L = LW'(PATH_CAPACITY);
    localparam logic [LW-1:0] ONE_L = LW'(1);
    localparam logic [LW-1:0] TWO_L = LW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOTS,
        S_CHAR,
        S_BACK,
        S_FIN,
        S_FIN_LAST,
        S_READ,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    pcan_pkg::cmd_t    cmd_reg, cmd_next, cur;
    logic [1:0]        dots_reg, dots_next;
    logic [LW-1:0]     wl_reg, wl_next, wl_m1, wl_m2, wl_set_val;
    logic [7:0]        last_reg, last_next, last_set_val;
    logic              err_reg, err_next;
    logic [7:0]        char_reg, char_next;
    logic              res_valid_reg;
    pcan_pkg::result_t res_reg, res_new;

    logic [7:0]        mem [PATH_CAPACITY];
    logic [7:0]        rd_data_reg;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_we;

    logic              put_en, root_en, wl_set, last_set, done, load, res_free;
    logic [7:0]        put_byte;
    logic              need_slash;
    logic [CW-1:0]     idx_q, idx_c, wl_c;
    logic              in_range;
    logic [XW-1:0]     wl_x;

    assign cur      = (state_reg == S_IDLE) ? q_data : cmd_reg;
    assign wl_m1    = wl_reg - ONE_L;
    assign wl_m2    = wl_reg - TWO_L;
    assign idx_q    = CW'(q_data.read_index);
    assign idx_c    = CW'(cmd_reg.read_index);
    assign wl_c     = CW'(wl_reg);
    assign in_range = (idx_c < wl_c);
    assign res_free = !res_valid_reg || !result_stall;
    assign load     = done && res_free;

    always_comb
    begin
        case (q_data.pre)
            pcan_pkg::PRE_OPEN:   need_slash = (wl_reg != '0) && (last_reg != pcan_pkg::CH_SLASH);
            pcan_pkg::PRE_ENSURE: need_slash = (wl_reg == '0) || (last_reg != pcan_pkg::CH_SLASH);
            default:              need_slash = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        dots_next    = dots_reg;
        char_next    = char_reg;
        pop          = 1'b0;
        put_en       = 1'b0;
        put_byte     = cur.ch;
        root_en      = 1'b0;
        wl_set       = 1'b0;
        wl_set_val   = wl_m1;
        last_set     = 1'b0;
        last_set_val = pcan_pkg::CH_SLASH;
        mem_raddr    = wl_m2[AW-1:0];
        done         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = q_data;
                    dots_next = q_data.dots;
                    char_next = '0;
                    case (q_data.kind)
                        pcan_pkg::CMD_APPEND:
                        begin
                            if (q_data.pre == pcan_pkg::PRE_NONE && q_data.dots == 2'd0)
                            begin
                                put_en = 1'b1;
                                done   = 1'b1;
                            end
                            else
                            begin
                                put_en   = need_slash;
                                put_byte = pcan_pkg::CH_SLASH;
                                if (q_data.dots != 2'd0)
                                begin
                                    state_next = S_DOTS;
                                end
                                else if (q_data.with_char)
                                begin
                                    state_next = S_CHAR;
                                end
                                else
                                begin
                                    done = 1'b1;
                                end
                            end
                        end
                        pcan_pkg::CMD_ROOT:
                        begin
                            root_en = 1'b1;
                            done    = 1'b1;
                        end
                        pcan_pkg::CMD_BACKUP,
                        pcan_pkg::CMD_FINISH:
                        begin
                            if (q_data.kind == pcan_pkg::CMD_FINISH && !q_data.fin_backup)
                            begin
                                state_next = S_FIN;
                            end
                            else if (wl_reg <= ONE_L)
                            begin
                                if (q_data.kind == pcan_pkg::CMD_FINISH)
                                begin
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    done = 1'b1;
                                end
                            end
                            else
                            begin
                                wl_set     = 1'b1;
                                state_next = S_BACK;
                            end
                        end
                        pcan_pkg::CMD_READ:
                        begin
                            mem_raddr  = idx_q[AW-1:0];
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_DOTS:
            begin
                put_en    = 1'b1;
                put_byte  = pcan_pkg::CH_DOT;
                dots_next = dots_reg - 2'd1;
                if (dots_reg == 2'd1)
                begin
                    if (cmd_reg.with_char)
                    begin
                        state_next = S_CHAR;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            S_CHAR:
            begin
                put_en = 1'b1;
                done   = 1'b1;
            end
            S_BACK:
            begin
                if (wl_reg == '0 || rd_data_reg == pcan_pkg::CH_SLASH)
                begin
                    last_set = 1'b1;
                    if (cmd_reg.kind == pcan_pkg::CMD_FINISH)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    wl_set = 1'b1;
                end
            end
            S_FIN:
            begin
                if (wl_reg > ONE_L && last_reg == pcan_pkg::CH_SLASH)
                begin
                    wl_set     = 1'b1;
                    state_next = S_FIN_LAST;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            S_FIN_LAST:
            begin
                last_set     = 1'b1;
                last_set_val = rd_data_reg;
                done         = 1'b1;
            end
            S_READ:
            begin
                char_next = in_range ? rd_data_reg : '0;
                done      = 1'b1;
            end
            S_RESULT:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (done)
        begin
            state_next = res_free ? S_IDLE : S_RESULT;
        end
    end

    always_comb
    begin
        wl_next   = wl_reg;
        last_next = last_reg;
        err_next  = err_reg;
        mem_we    = 1'b0;
        mem_waddr = wl_reg[AW-1:0];
        mem_wdata = put_byte;
        if (root_en)
        begin
            wl_next   = ONE_L;
            last_next = pcan_pkg::CH_SLASH;
            err_next  = 1'b0;
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = pcan_pkg::CH_SLASH;
        end
        else if (put_en && !err_reg)
        begin
            if (wl_reg == CAP_L)
            begin
                err_next = 1'b1;
            end
            else
            begin
                mem_we    = 1'b1;
                wl_next   = wl_reg + ONE_L;
                last_next = put_byte;
            end
        end
        else if (wl_set)
        begin
            wl_next = wl_set_val;
        end
        if (last_set)
        begin
            last_next = last_set_val;
        end
    end

    assign wl_x = XW'(wl_next);

    always_comb
    begin
        if (err_next)
        begin
            res_new.status = pcan_pkg::ST_TOO_LONG;
        end
        else if (!cur.started)
        begin
            res_new.status = pcan_pkg::ST_EMPTY;
        end
        else
        begin
            res_new.status = pcan_pkg::ST_OK;
        end
        res_new.result_length = wl_x[12:0];
        res_new.char_out      = char_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            dots_reg      <= 2'd0;
            wl_reg        <= '0;
            last_reg      <= '0;
            err_reg       <= 1'b0;
            char_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            dots_reg  <= dots_next;
            wl_reg    <= wl_next;
            last_reg  <= last_next;
            err_reg   <= err_next;
            char_reg  <= char_next;
            if (load)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_new;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n) wl_reg <= CAP_L)
        else $error("write length beyond capacity");
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (root_en || (!err_reg && wl_reg < CAP_L)))
        else $error("buffer write while overflowed or full");
    a_back_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BACK && wl_reg != '0 && rd_data_reg != pcan_pkg::CH_SLASH)
        |=> (wl_reg == $past(wl_m1)))
        else $error("back-up walk did not step one character");

endmodule

// ===== rtl/core/path_canonicalizer.sv =====
// path_canonicalizer: top level; front end, command queue and back end.
// Depends on pcan_pkg, pcan_front, pcan_queue, pcan_back.
//
// channel  direction  handshake                  payload
// item     in         item_valid / item_stall    pcan_pkg::item_t
// result   out        result_valid / result_stall pcan_pkg::result_t
//
// Base and in-name characters are written to the buffer straight from the idle state;
// the first character of a component first places the separator where needed, then any
// "." or ".." bytes, then the character itself, one appended byte per step (write port).
// ".." walks back over the removed component one character per step (read port walk).
// Finish drops a trailing separator after any walk; read uses a registered buffer read.
// Reset clears length, phase and error; the buffer itself is not cleared.
// A two-entry queue keeps the front accepting, until both entries are full, while the
// back end works or the result register is held by result_stall.
module path_canonicalizer #(
    parameter int PATH_CAPACITY = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pcan_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output pcan_pkg::result_t result
);

    logic           push, pop, q_full, q_empty;
    pcan_pkg::cmd_t push_cmd, pop_cmd;

    pcan_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    pcan_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    pcan_back #(
        .PATH_CAPACITY (PATH_CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
